// ===== sv/wggc_pkg.sv =====
package wggc_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_POSE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	// Job kinds after classification
	localparam logic [1:0] JOB_ADD  = 2'd0;
	localparam logic [1:0] JOB_POSE = 2'd1;
	localparam logic [1:0] JOB_TICK = 2'd2;
	localparam logic [1:0] JOB_NOP  = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LIN_GAIN  = 2'd1;
	localparam logic [1:0] REG_ANG_GAIN  = 2'd2;

	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int SQRT_STEPS       = 16;

	localparam logic signed [16:0] PI_Q12      = 17'sd12868;
	localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
	localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;

	localparam logic [14:0] THR_RESET = 15'd1024;
	localparam logic [3:0]  LG_RESET  = 4'd2;
	localparam logic [3:0]  AG_RESET  = 4'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [14:0] tx;
		logic [14:0] ty;
		logic [7:0]  id;
		logic [14:0] px;
		logic [14:0] py;
		logic [14:0] ph;
	} job_t;

	typedef struct packed {
		logic [14:0] thr;
		logic [3:0]  lin_gain;
		logic [3:0]  ang_gain;
	} cfg_t;

	// Arctangent of 2^-i in Q.20
	function automatic logic [19:0] atan_q20(input logic [4:0] i);
		logic [19:0] r;
		case (i)
			5'd0:  r = 20'd823550;
			5'd1:  r = 20'd486170;
			5'd2:  r = 20'd256879;
			5'd3:  r = 20'd130396;
			5'd4:  r = 20'd65451;
			5'd5:  r = 20'd32757;
			5'd6:  r = 20'd16383;
			5'd7:  r = 20'd8192;
			5'd8:  r = 20'd4096;
			5'd9:  r = 20'd2048;
			5'd10: r = 20'd1024;
			5'd11: r = 20'd512;
			5'd12: r = 20'd256;
			5'd13: r = 20'd128;
			5'd14: r = 20'd64;
			5'd15: r = 20'd32;
			5'd16: r = 20'd16;
			5'd17: r = 20'd8;
			5'd18: r = 20'd4;
			5'd19: r = 20'd2;
			5'd20: r = 20'd1;
			5'd21: r = 20'd1;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/waypoint_go_to_goal_controller_unit.sv =====
// Waypoint go-to-goal controller.
// Input channel (in_valid/in_stall) carries one command per beat: add a
// target to the waypoint queue, store a pose and step, or step with the
// stored pose. Every input beat yields exactly one result beat on the
// output channel (out_valid/out_stall), in order.
// A front stage classifies beats into a two-entry job queue; the back
// stage runs one job at a time. Add and idle commands go from the job
// queue to the DONE state and then to the output register; a step with a
// queued target passes READ, SQ1, SQ2, the ITER loop, ERR and, unless it
// arrives, MUL before DONE. The ITER loop, shared by square root and
// CORDIC, has ITERS = max(16, min(CORDIC_STEPS, 24)) steps. The back stage
// takes no new job until the last job's result is in the output register.
// The config port (cfg_valid/cfg_ready) is always ready; write it only
// while the block is idle. Reset clears the queue, the stored pose and
// loads threshold 1024, gains 2 and 5. When out_stall is high the result
// beat holds; the back stage then waits and the job queue fills, after
// which in_stall rises.
module waypoint_go_to_goal_controller_unit
	import wggc_pkg::*;
#(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [14:0]        target_x,
	input  logic [14:0]        target_y,
	input  logic [7:0]         target_id,
	input  logic [14:0]        pose_x,
	input  logic [14:0]        pose_y,
	input  logic signed [14:0] pose_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               add_accepted,
	output logic               drive_valid,
	output logic [19:0]        linear_speed,
	output logic signed [18:0] turn_rate,
	output logic               target_reached,
	output logic [7:0]         reached_id
);

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic job_pop;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{thr: THR_RESET, lin_gain: LG_RESET, ang_gain: AG_RESET};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.thr      <= cfg_data;
				REG_LIN_GAIN:  cfg_q.lin_gain <= cfg_data[3:0];
				REG_ANG_GAIN:  cfg_q.ang_gain <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	wggc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.target_x     (target_x),
		.target_y     (target_y),
		.target_id    (target_id),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_heading (pose_heading),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop)
	);

	wggc_back #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.job_valid      (job_valid),
		.job            (job),
		.job_pop        (job_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.add_accepted   (add_accepted),
		.drive_valid    (drive_valid),
		.linear_speed   (linear_speed),
		.turn_rate      (turn_rate),
		.target_reached (target_reached),
		.reached_id     (reached_id)
	);

endmodule

// ===== sv/wggc_ram.sv =====
module wggc_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/wggc_front.sv =====
module wggc_front
	import wggc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [14:0] target_x,
	input  logic [14:0] target_y,
	input  logic [7:0]  target_id,
	input  logic [14:0] pose_x,
	input  logic [14:0] pose_y,
	input  logic [14:0] pose_heading,
	output logic        job_valid,
	output job_t        job,
	input  logic        job_pop
);

	job_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	job_t       cls;

	// Classify the incoming beat
	always_comb begin
		cls = '{kind: JOB_NOP, tx: target_x, ty: target_y, id: target_id,
			px: pose_x, py: pose_y, ph: pose_heading};
		unique case (command)
			CMD_ADD:  cls.kind = JOB_ADD;
			CMD_POSE: cls.kind = JOB_POSE;
			CMD_TICK: cls.kind = JOB_TICK;
			default:  cls.kind = JOB_NOP;
		endcase
	end

	assign in_stall  = cnt_q[1];
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = slot_q[rd_q];

	// Hold the payload of queued jobs
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (job_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

endmodule

// ===== sv/wggc_back.sv =====
module wggc_back
	import wggc_pkg::*;
#(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               job_valid,
	input  job_t               job,
	output logic               job_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               add_accepted,
	output logic               drive_valid,
	output logic [19:0]        linear_speed,
	output logic signed [18:0] turn_rate,
	output logic               target_reached,
	output logic [7:0]         reached_id
);

	localparam int AW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int ITERS  = (NSTEPS > SQRT_STEPS) ? NSTEPS : SQRT_STEPS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SQ1  = 3'd2;
	localparam logic [2:0] ST_SQ2  = 3'd3;
	localparam logic [2:0] ST_ITER = 3'd4;
	localparam logic [2:0] ST_ERR  = 3'd5;
	localparam logic [2:0] ST_MUL  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic [14:0]        sx_q;
	logic [14:0]        sy_q;
	logic [14:0]        sh_q;

	logic               ram_we;
	logic               ram_re;
	logic [37:0]        ram_rdata;

	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic [7:0]         id_q;
	logic [31:0]        sq_q;
	logic [17:0]        rem_q;
	logic [15:0]        root_q;
	logic signed [26:0] x_q;
	logic signed [26:0] y_q;
	logic signed [23:0] z_q;
	logic [4:0]         cnt_q;
	logic signed [16:0] err_q;

	logic               r_acc_q;
	logic               r_drv_q;
	logic [19:0]        r_lin_q;
	logic signed [18:0] r_turn_q;
	logic               r_reach_q;
	logic [7:0]         r_id_q;

	logic               full;
	logic               out_free;

	logic [17:0]        rem_n;
	logic [17:0]        trial;
	logic signed [26:0] xsh;
	logic signed [26:0] ysh;
	logic signed [23:0] ang;
	logic signed [26:0] x0;
	logic signed [26:0] y0;
	logic signed [23:0] zr;
	logic signed [16:0] bear;
	logic signed [16:0] head17;
	logic signed [16:0] e0;
	logic signed [16:0] e1;
	logic signed [16:0] e2;
	logic signed [21:0] turn_p;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign out_free = !out_valid || !out_stall;
	assign job_pop  = (state_q == ST_IDLE) && job_valid;
	assign ram_we   = job_pop && (job.kind == JOB_ADD) && !full;
	assign ram_re   = job_pop && (job.kind == JOB_POSE || job.kind == JOB_TICK);

	wggc_ram #(.WIDTH(38), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({job.id, job.ty, job.tx}),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// Square root digit step
	assign rem_n = {rem_q[15:0], sq_q[31:30]};
	assign trial = {root_q, 2'b01};

	// CORDIC vectoring step
	assign xsh = x_q >>> cnt_q;
	assign ysh = y_q >>> cnt_q;
	assign ang = {4'b0, atan_q20(cnt_q)};

	// Quarter-turn pre-rotation of the scaled vector
	always_comb begin
		x0 = {{3{dx_q[15]}}, dx_q, 8'b0};
		y0 = {{3{dy_q[15]}}, dy_q, 8'b0};
		if (dx_q[15]) begin
			if (!dy_q[15]) begin
				x0 = {{3{dy_q[15]}}, dy_q, 8'b0};
				y0 = -{{3{dx_q[15]}}, dx_q, 8'b0};
			end else begin
				x0 = -{{3{dy_q[15]}}, dy_q, 8'b0};
				y0 = {{3{dx_q[15]}}, dx_q, 8'b0};
			end
		end
	end

	// Round bearing and wrap heading error
	always_comb begin
		zr     = z_q + 24'sd128;
		bear   = zr[23:8] >= 16'sh8000 ? {1'b1, zr[23:8]} : {zr[23], zr[23:8]};
		head17 = {{2{sh_q[14]}}, sh_q};
		e0     = bear - head17;
		e1     = (e0 > PI_Q12) ? e0 - TWO_PI_Q12 : e0;
		e2     = (e1 < -PI_Q12) ? e1 + TWO_PI_Q12 : e1;
	end

	assign turn_p = $signed({1'b0, cfg.ang_gain}) * err_q;

	// Sequence one job at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sh_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						r_acc_q   <= 1'b0;
						r_drv_q   <= 1'b0;
						r_lin_q   <= '0;
						r_turn_q  <= '0;
						r_reach_q <= 1'b0;
						r_id_q    <= '0;
						state_q   <= ST_DONE;
						case (job.kind)
							JOB_ADD: begin
								if (!full) begin
									r_acc_q <= 1'b1;
									tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0
										: tail_q + 1'b1;
									count_q <= count_q + 1'b1;
								end
							end
							JOB_POSE, JOB_TICK: begin
								if (job.kind == JOB_POSE) begin
									sx_q <= job.px;
									sy_q <= job.py;
									sh_q <= job.ph;
								end
								if (count_q != '0) begin
									state_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					dx_q    <= $signed({1'b0, ram_rdata[14:0]}) - $signed({1'b0, sx_q});
					dy_q    <= $signed({1'b0, ram_rdata[29:15]}) - $signed({1'b0, sy_q});
					id_q    <= ram_rdata[37:30];
					state_q <= ST_SQ1;
				end
				ST_SQ1: begin
					sq_q    <= 32'(dx_q * dx_q);
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					sq_q    <= sq_q + 32'(dy_q * dy_q);
					rem_q   <= '0;
					root_q  <= '0;
					x_q     <= x0;
					y_q     <= y0;
					z_q     <= dx_q[15] ? (dy_q[15] ? -HALF_PI_Q20 : HALF_PI_Q20) : '0;
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (cnt_q < 5'(SQRT_STEPS)) begin
						sq_q <= {sq_q[29:0], 2'b00};
						if (rem_n >= trial) begin
							rem_q  <= rem_n - trial;
							root_q <= {root_q[14:0], 1'b1};
						end else begin
							rem_q  <= rem_n;
							root_q <= {root_q[14:0], 1'b0};
						end
					end
					if (cnt_q < 5'(NSTEPS)) begin
						if (!y_q[26]) begin
							x_q <= x_q + ysh;
							y_q <= y_q - xsh;
							z_q <= z_q + ang;
						end else begin
							x_q <= x_q - ysh;
							y_q <= y_q + xsh;
							z_q <= z_q - ang;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(ITERS - 1)) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					r_drv_q <= 1'b1;
					err_q   <= e2;
					if (root_q > {1'b0, cfg.thr}) begin
						state_q <= ST_MUL;
					end else begin
						r_reach_q <= 1'b1;
						r_id_q    <= id_q;
						head_q    <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_q   <= count_q - 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_MUL: begin
					r_lin_q  <= 20'(cfg.lin_gain * root_q);
					r_turn_q <= turn_p[18:0];
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_DONE) begin
			add_accepted   <= r_acc_q;
			drive_valid    <= r_drv_q;
			linear_speed   <= r_lin_q;
			turn_rate      <= r_turn_q;
			target_reached <= r_reach_q;
			reached_id     <= r_id_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_reach_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_reached |-> drive_valid && linear_speed == '0)
		else $error("arrival without drive or with speed");
	a_add_nodrive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && add_accepted |-> !drive_valid && !target_reached)
		else $error("add beat carries drive");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> state_q != ST_IDLE)
		else $error("job popped without work");
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("queue write and read together");

endmodule
